>>> hw/rtl/esc4_pkg.sv
// shared types, register codes and constants for the four-channel pwm block
// no dependencies
`default_nettype none

package esc4_pkg;

    localparam int CHANNELS     = 4;
    localparam int LEVEL_FIELDS = 4;
    localparam int CNT_W        = 16;
    localparam int MOTOR_W      = 2;

    localparam logic [CNT_W-1:0] RESET_COMPARE      = 16'd1000;
    localparam logic [CNT_W-1:0] RESET_PRESCALE_TOP = 16'd15;
    localparam logic [CNT_W-1:0] RESET_PERIOD_TOP   = 16'd19999;
    localparam logic [CNT_W-1:0] RESET_MIN_PULSE    = 16'd1000;
    localparam logic [CNT_W-1:0] RESET_MAX_PULSE    = 16'd2000;

    typedef logic [CNT_W-1:0] count_t;

    typedef enum logic [0:0] {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        CFG_PRESCALE_TOP = 2'd0,
        CFG_PERIOD_TOP   = 2'd1,
        CFG_MIN_PULSE    = 2'd2,
        CFG_MAX_PULSE    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        count_t prescale_top;
        count_t period_top;
        count_t min_pulse;
        count_t max_pulse;
    } cfg_t;

    typedef struct packed {
        op_t                op;
        logic [MOTOR_W-1:0] motor;
        count_t             pulse_width;
    } in_item_t;

    typedef struct packed {
        logic   level_front_left;
        logic   level_front_right;
        logic   level_back_left;
        logic   level_back_right;
        logic   period_wrapped;
        count_t count_now;
    } out_item_t;

    function automatic count_t clamp_width(count_t w, count_t lo, count_t hi);
        count_t t;
        t = (w < lo) ? lo : w;
        return (t > hi) ? hi : t;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/esc4_cfg.sv
// configuration registers of the pwm block
// depends on esc4_pkg
`default_nettype none

module esc4_cfg (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire esc4_pkg::cfg_index_t  cfg_index,
    input  wire esc4_pkg::count_t      cfg_data,
    output esc4_pkg::cfg_t             cfg
);

    esc4_pkg::cfg_t cfg_reg;
    esc4_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                esc4_pkg::CFG_PRESCALE_TOP: cfg_next.prescale_top = cfg_data;
                esc4_pkg::CFG_PERIOD_TOP:   cfg_next.period_top   = cfg_data;
                esc4_pkg::CFG_MIN_PULSE:    cfg_next.min_pulse    = cfg_data;
                esc4_pkg::CFG_MAX_PULSE:    cfg_next.max_pulse    = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prescale_top <= esc4_pkg::RESET_PRESCALE_TOP;
            cfg_reg.period_top   <= esc4_pkg::RESET_PERIOD_TOP;
            cfg_reg.min_pulse    <= esc4_pkg::RESET_MIN_PULSE;
            cfg_reg.max_pulse    <= esc4_pkg::RESET_MAX_PULSE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> hw/rtl/esc4_core.sv
// timer state, compare registers and per-item result logic
// depends on esc4_pkg
`default_nettype none

module esc4_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire esc4_pkg::in_item_t item,
    input  wire esc4_pkg::cfg_t     cfg,
    output esc4_pkg::out_item_t     result
);

    esc4_pkg::count_t prescale_count_reg;
    esc4_pkg::count_t prescale_count_next;
    esc4_pkg::count_t period_count_reg;
    esc4_pkg::count_t period_count_next;
    esc4_pkg::count_t pending_reg [esc4_pkg::CHANNELS];
    esc4_pkg::count_t pending_next [esc4_pkg::CHANNELS];
    esc4_pkg::count_t active_reg [esc4_pkg::CHANNELS];
    esc4_pkg::count_t active_next [esc4_pkg::CHANNELS];

    logic                              is_tick;
    logic                              prescale_roll;
    logic                              period_roll;
    logic                              wrapped;
    esc4_pkg::count_t                  clamped;
    logic [esc4_pkg::LEVEL_FIELDS-1:0] level;

    assign is_tick       = (item.op == esc4_pkg::OP_TICK);
    assign prescale_roll = (prescale_count_reg >= cfg.prescale_top);
    assign period_roll   = (period_count_reg >= cfg.period_top);
    assign wrapped       = is_tick && prescale_roll && period_roll;
    assign clamped       = esc4_pkg::clamp_width(item.pulse_width, cfg.min_pulse,
                                                 cfg.max_pulse);

    always_comb
    begin
        prescale_count_next = prescale_count_reg;
        period_count_next   = period_count_reg;
        if (is_tick)
        begin
            if (prescale_roll)
            begin
                prescale_count_next = '0;
                period_count_next   = period_roll ? '0 : period_count_reg + 1'b1;
            end
            else
            begin
                prescale_count_next = prescale_count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < esc4_pkg::CHANNELS; k++)
        begin
            pending_next[k] = pending_reg[k];
            active_next[k]  = wrapped ? pending_reg[k] : active_reg[k];
            if (!is_tick && (32'(item.motor) == k))
            begin
                pending_next[k] = clamped;
            end
        end
    end

    // channels beyond the configured count read low
    for (genvar g = 0; g < esc4_pkg::LEVEL_FIELDS; g++)
    begin : g_level
        if (g < esc4_pkg::CHANNELS)
        begin : g_on
            assign level[g] = (period_count_next < active_next[g]);
        end
        else
        begin : g_off
            assign level[g] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_count_reg <= '0;
            period_count_reg   <= '0;
            for (int k = 0; k < esc4_pkg::CHANNELS; k++)
            begin
                pending_reg[k] <= esc4_pkg::RESET_COMPARE;
                active_reg[k]  <= esc4_pkg::RESET_COMPARE;
            end
        end
        else if (step)
        begin
            prescale_count_reg <= prescale_count_next;
            period_count_reg   <= period_count_next;
            for (int k = 0; k < esc4_pkg::CHANNELS; k++)
            begin
                pending_reg[k] <= pending_next[k];
                active_reg[k]  <= active_next[k];
            end
        end
    end

    always_comb
    begin
        result.level_front_left  = level[0];
        result.level_front_right = level[1];
        result.level_back_left   = level[2];
        result.level_back_right  = level[3];
        result.period_wrapped    = wrapped;
        result.count_now         = period_count_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/esc_four_channel_pwm.sv
// top level of the four-channel motor pulse generator
// depends on esc4_pkg, esc4_cfg, esc4_core
`default_nettype none

// Each item is either one timer tick or a pulse-width write for one channel,
// and every item returns one result holding the four channel levels, the
// wrap flag and the period count after that item. Items are taken at one per
// clock while ready is high: an item is held in the input register, passes
// the timer and compare logic, and its result lands in the output register,
// where it is shown until it is taken. The output register lets the next
// item be taken while a result waits; only when both registers are full and
// the result is not taken does ready drop. Configuration registers are
// written through the plain write port and must be changed only while no
// item is in flight.

module esc_four_channel_pwm (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire esc4_pkg::in_item_t    item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output esc4_pkg::out_item_t        result,
    input  wire logic                  cfg_we,
    input  wire esc4_pkg::cfg_index_t  cfg_index,
    input  wire esc4_pkg::count_t      cfg_data
);

    logic                in_valid_reg;
    logic                in_valid_next;
    esc4_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    esc4_pkg::out_item_t out_item_reg;
    esc4_pkg::out_item_t core_result;
    esc4_pkg::cfg_t      cfg;
    logic                advance;
    logic                take;

    esc4_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    esc4_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || result_ready);
    assign item_ready     = !in_valid_reg || advance;
    assign take           = item_valid && item_ready;
    assign in_valid_next  = take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            out_item_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

endmodule

`default_nettype wire

>>> hw/rtl/esc4_checker.sv
// port-level checks for the four-channel pwm block, bound to the top level
// depends on esc4_pkg and esc_four_channel_pwm
`default_nettype none

module esc4_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 item_valid,
    input wire logic                 item_ready,
    input wire esc4_pkg::in_item_t   item,
    input wire logic                 result_valid,
    input wire logic                 result_ready,
    input wire esc4_pkg::out_item_t  result
);

    // nothing comes out while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !result_valid)
        else $error("result valid during reset");

    // a wrap always lands the counter on zero
    a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.period_wrapped) |-> (result.count_now == '0))
        else $error("wrap with nonzero count");

    // input only stalls when a result is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (result_valid && !result_ready))
        else $error("input stalled without output backpressure");

    // a held result does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))
        else $error("stalled result changed");

    // a waiting input item stays offered and unchanged
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_ready) |=> (item_valid && $stable(item)))
        else $error("waiting input item changed");

endmodule

bind esc_four_channel_pwm esc4_checker u_esc4_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

>>> tb/sv/esc4_checker.sv
`timescale 1ns / 100ps
// scoreboard for the four-channel pwm block: tracks the timer, the compares and the registers
// and compares every result with its prediction; depends on esc4_pkg

module esc4_scoreboard (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_ready,
    input  esc4_pkg::in_item_t             item,
    input  logic                           result_valid,
    input  logic                           result_ready,
    input  esc4_pkg::out_item_t            result,
    input  logic                           cfg_we,
    input  esc4_pkg::cfg_index_t           cfg_index,
    input  esc4_pkg::count_t               cfg_data,
    output int unsigned                    errors,
    output int unsigned                    outstanding
);

    esc4_pkg::count_t    prescale_top;
    esc4_pkg::count_t    period_top;
    esc4_pkg::count_t    min_pulse;
    esc4_pkg::count_t    max_pulse;
    esc4_pkg::count_t    prescale_cnt;
    esc4_pkg::count_t    period_cnt;
    esc4_pkg::count_t    pending_cmp [esc4_pkg::CHANNELS];
    esc4_pkg::count_t    active_cmp [esc4_pkg::CHANNELS];
    esc4_pkg::out_item_t levels_due [$];
    esc4_pkg::out_item_t predicted;
    esc4_pkg::out_item_t oldest;
    int unsigned         fail_count;

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic step_timer(input esc4_pkg::in_item_t it, output esc4_pkg::out_item_t r);
        esc4_pkg::count_t w;
        logic             wrapped;
        wrapped = 1'b0;
        if (it.op == esc4_pkg::OP_TICK)
        begin
            if (prescale_cnt < prescale_top)
                prescale_cnt = prescale_cnt + 1'b1;
            else
            begin
                prescale_cnt = '0;
                if (period_cnt < period_top)
                    period_cnt = period_cnt + 1'b1;
                else
                begin
                    period_cnt = '0;
                    for (int k = 0; k < esc4_pkg::CHANNELS; k++)
                        active_cmp[k] = pending_cmp[k];
                    wrapped = 1'b1;
                end
            end
        end
        else if (it.motor < esc4_pkg::CHANNELS)
        begin
            w = it.pulse_width;
            if (w < min_pulse)
                w = min_pulse;
            if (w > max_pulse)
                w = max_pulse;
            pending_cmp[it.motor] = w;
        end
        r.level_front_left  = period_cnt < active_cmp[0];
        r.level_front_right = period_cnt < active_cmp[1];
        r.level_back_left   = period_cnt < active_cmp[2];
        r.level_back_right  = period_cnt < active_cmp[3];
        r.period_wrapped    = wrapped;
        r.count_now         = period_cnt;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prescale_top = esc4_pkg::RESET_PRESCALE_TOP;
            period_top   = esc4_pkg::RESET_PERIOD_TOP;
            min_pulse    = esc4_pkg::RESET_MIN_PULSE;
            max_pulse    = esc4_pkg::RESET_MAX_PULSE;
            prescale_cnt = '0;
            period_cnt   = '0;
            for (int k = 0; k < esc4_pkg::CHANNELS; k++)
            begin
                pending_cmp[k] = esc4_pkg::RESET_COMPARE;
                active_cmp[k]  = esc4_pkg::RESET_COMPARE;
            end
            levels_due.delete();
            fail_count = 0;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    esc4_pkg::CFG_PRESCALE_TOP: prescale_top = cfg_data;
                    esc4_pkg::CFG_PERIOD_TOP:   period_top   = cfg_data;
                    esc4_pkg::CFG_MIN_PULSE:    min_pulse    = cfg_data;
                    esc4_pkg::CFG_MAX_PULSE:    max_pulse    = cfg_data;
                    default:                    ;
                endcase
            end
            if (result_valid && result_ready)
            begin
                if (levels_due.size() == 0)
                begin
                    $error("result with no item outstanding: count_now %0d",
                           result.count_now);
                    fail_count++;
                end
                else
                begin
                    oldest = levels_due.pop_front();
                    check_field("level_front_left", oldest.level_front_left,
                                result.level_front_left);
                    check_field("level_front_right", oldest.level_front_right,
                                result.level_front_right);
                    check_field("level_back_left", oldest.level_back_left,
                                result.level_back_left);
                    check_field("level_back_right", oldest.level_back_right,
                                result.level_back_right);
                    check_field("period_wrapped", oldest.period_wrapped,
                                result.period_wrapped);
                    check_field("count_now", oldest.count_now, result.count_now);
                end
            end
            if (item_valid && item_ready)
            begin
                step_timer(item, predicted);
                levels_due.push_back(predicted);
            end
            errors      <= fail_count;
            outstanding <= levels_due.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench top for esc_four_channel_pwm: drives directed and random items and register
// settings, randomly stalls both sides; depends on esc4_pkg and esc4_scoreboard

module tb;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 150;
    localparam int unsigned PHASES         = 8;
    localparam int unsigned PHASE_ITEMS    = 88;

    logic                 clk          = 1'b0;
    logic                 rst_n;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    esc4_pkg::in_item_t   item         = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    esc4_pkg::out_item_t  result;
    logic                 cfg_we       = 1'b0;
    esc4_pkg::cfg_index_t cfg_index    = esc4_pkg::CFG_PRESCALE_TOP;
    esc4_pkg::count_t     cfg_data     = '0;
    logic                 calm         = 1'b0;
    logic                 hold_req     = 1'b0;
    int unsigned          errors;
    int unsigned          outstanding;

    always #10 clk = ~clk;

    esc_four_channel_pwm dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    esc4_scoreboard u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    task automatic send_item(esc4_pkg::op_t kind, logic [esc4_pkg::MOTOR_W-1:0] chan,
                             esc4_pkg::count_t width);
        if (!calm && $urandom_range(99) < 28)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{op: kind, motor: chan, pulse_width: width};
        do @(posedge clk); while (!item_ready);
    endtask

    task automatic tick_n(int unsigned n);
        repeat (n)
            send_item(esc4_pkg::OP_TICK, esc4_pkg::MOTOR_W'($urandom_range(3)),
                      esc4_pkg::count_t'($urandom_range(65535)));
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_config(esc4_pkg::count_t pre, esc4_pkg::count_t per,
                               esc4_pkg::count_t lo, esc4_pkg::count_t hi);
        cfg_we    <= 1'b1;
        cfg_index <= esc4_pkg::CFG_PRESCALE_TOP;
        cfg_data  <= pre;
        @(posedge clk);
        cfg_index <= esc4_pkg::CFG_PERIOD_TOP;
        cfg_data  <= per;
        @(posedge clk);
        cfg_index <= esc4_pkg::CFG_MIN_PULSE;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= esc4_pkg::CFG_MAX_PULSE;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold when asked
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held         = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                result_ready <= calm || ($urandom_range(99) >= 28);
        end
    end

    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (item_valid && item_ready)
                || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        esc4_pkg::op_t    kind;
        esc4_pkg::count_t width;
        esc4_pkg::count_t pre;
        esc4_pkg::count_t per;
        esc4_pkg::count_t lo;
        esc4_pkg::count_t hi;

        rst_n <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits clamp to 1000..2000
        send_item(esc4_pkg::OP_WRITE, 2'd0, 16'h0000);
        send_item(esc4_pkg::OP_WRITE, 2'd1, 16'hFFFF);
        send_item(esc4_pkg::OP_WRITE, 2'd2, 16'd1500);
        send_item(esc4_pkg::OP_TICK, 2'd3, 16'hFFFF);
        send_item(esc4_pkg::OP_TICK, 2'd0, 16'h0000);
        drain();

        // widest limits, writes land on the wrap
        load_config(16'd0, 16'd3, 16'd0, 16'hFFFF);
        send_item(esc4_pkg::OP_WRITE, 2'd0, 16'h0000);
        send_item(esc4_pkg::OP_WRITE, 2'd1, 16'hFFFF);
        send_item(esc4_pkg::OP_WRITE, 2'd2, 16'd2);
        send_item(esc4_pkg::OP_WRITE, 2'd3, 16'd1);
        tick_n(4);
        drain();

        // crossed limits: max wins
        load_config(16'd0, 16'd3, 16'd9, 16'd4);
        send_item(esc4_pkg::OP_WRITE, 2'd3, 16'h0000);
        send_item(esc4_pkg::OP_WRITE, 2'd2, 16'hFFFF);
        tick_n(1);
        drain();

        // period counter left above a lowered top
        load_config(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        tick_n(5);
        drain();
        load_config(16'd0, 16'd2, 16'd0, 16'hFFFF);
        tick_n(1);
        drain();

        // prescaler left above a lowered top
        load_config(16'hFFFF, 16'd2, 16'd0, 16'hFFFF);
        tick_n(3);
        drain();
        load_config(16'd1, 16'd2, 16'd0, 16'hFFFF);
        tick_n(1);
        drain();

        // zero period top wraps on every step
        load_config(16'd0, 16'd0, 16'd0, 16'hFFFF);
        tick_n(2);
        drain();

        for (int unsigned phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    pre = 16'd0;
                    per = esc4_pkg::count_t'($urandom_range(1, 12));
                    lo  = 16'd0;
                    hi  = 16'hFFFF;
                end
                6:
                begin
                    pre = 16'd0;
                    per = 16'd0;
                    lo  = esc4_pkg::count_t'($urandom_range(15));
                    hi  = esc4_pkg::count_t'($urandom_range(35));
                end
                7:
                begin
                    pre = 16'hFFFF;
                    per = 16'hFFFF;
                    lo  = 16'hFFFF;
                    hi  = 16'hFFFF;
                end
                default:
                begin
                    pre = esc4_pkg::count_t'($urandom_range(3));
                    per = esc4_pkg::count_t'($urandom_range(1, 30));
                    lo  = esc4_pkg::count_t'($urandom_range(15));
                    hi  = esc4_pkg::count_t'($urandom_range(35));
                end
            endcase
            calm = (phase == 1);
            load_config(pre, per, lo, hi);
            if (phase == 3)
                hold_req <= 1'b1;
            for (int unsigned n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(99) < 65)
                    kind = esc4_pkg::OP_TICK;
                else
                    kind = esc4_pkg::OP_WRITE;
                if ($urandom_range(3) == 0)
                    width = esc4_pkg::count_t'($urandom_range(65535));
                else
                    width = esc4_pkg::count_t'($urandom_range(40));
                send_item(kind, esc4_pkg::MOTOR_W'($urandom_range(3)), width);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/esc4_pkg.sv
hw/rtl/esc4_cfg.sv
hw/rtl/esc4_core.sv
hw/rtl/esc_four_channel_pwm.sv
hw/rtl/esc4_checker.sv
tb/sv/esc4_checker.sv
tb/sv/tb.sv
